/* rtl/tcw_pkg.sv */
package tcw_pkg;

    // operation codes carried in the func field
    localparam logic [2:0] FN_PUT       = 3'd0;
    localparam logic [2:0] FN_NEWLINE   = 3'd1;
    localparam logic [2:0] FN_BACKSPACE = 3'd2;
    localparam logic [2:0] FN_CLEAR     = 3'd3;
    localparam logic [2:0] FN_READ      = 3'd4;

    localparam int CELL_W = 16;

    // space with attribute zero, character in the low byte
    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0020;

    typedef struct packed {
        logic [2:0]  func;
        logic [7:0]  char_code;
        logic [7:0]  attribute;
        logic [10:0] read_index;
    } req_t;

    typedef struct packed {
        logic [4:0] cursor_row;
        logic [6:0] cursor_col;
        logic [7:0] read_char;
        logic [7:0] read_attr;
    } rsp_t;

endpackage

/* rtl/tcw_if.sv */
interface tcw_req_if
    import tcw_pkg::*;
();
    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tcw_rsp_if
    import tcw_pkg::*;
();
    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/text_console_writer.sv */
// Text console engine: a ROWS x COLS screen of 16-bit cells (character in the
// low byte, attribute in the high byte) with a cursor. Each request transfer
// carries one operation (put, newline, backspace, clear, read) and yields
// exactly one response transfer with the cursor after the operation and, for
// a read, the addressed cell. All cell traffic goes through one simple
// dual-port RAM (one write, one registered read per cycle) under a small
// sequencer, and the block takes one request at a time. Put, newline without
// scroll, backspace, read and unused codes go straight to ST_RESP. Clear
// blanks one cell per cycle in ST_FILL. A newline on the last row, or a put
// that wraps there, scrolls: the copy sweep moves one cell per cycle through
// the RAM's read and write ports, then ST_DRAIN writes the last copy and
// ST_FILL blanks the bottom row. After reset the block runs a clearing pass
// over all ROWS*COLS cells (2000 at 25 x 80) before it raises ready. The
// response is held in an output register, and a new request is taken while
// an earlier response still waits.
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int ROWS = 25,
    parameter int COLS = 80
) (
    input  logic      clk,
    input  logic      rst_n,
    tcw_req_if.sink   req,
    tcw_rsp_if.source rsp
);

    localparam int CELLS = ROWS * COLS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLS);
    // wide enough for the read index field, a cell address and the cell count
    localparam int XW    = ((AW > 11) ? AW : 11) + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCROLL,
        ST_DRAIN,
        ST_FILL,
        ST_RESP
    } state_t;

    state_t          state_reg, state_next;
    logic [RW-1:0]   row_reg, row_next;
    logic [CW-1:0]   col_reg, col_next;
    logic [AW-1:0]   src_reg, src_next;     // scroll source address
    logic [AW-1:0]   dst_reg, dst_next;     // scroll destination of pending copy
    logic            pend_reg, pend_next;   // copy data arriving from ram
    logic [AW-1:0]   fill_reg, fill_next;   // blanking sweep address
    logic            fresp_reg, fresp_next; // blanking sweep ends in a response
    logic            rsel_reg, rsel_next;   // response carries the read cell
    logic            ovld_reg, ovld_next;
    rsp_t            odata_reg, odata_next;

    // cell ram port signals
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    logic [AW-1:0] pos;
    logic          col_last;
    logic          row_last;
    logic [XW-1:0] idx_x;
    logic          idx_ok;
    logic          line_feed;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // cursor cell address, constant multiply by COLS
    assign pos      = AW'(row_reg * COLS + col_reg);
    assign col_last = (col_reg == CW'(COLS - 1));
    assign row_last = (row_reg == RW'(ROWS - 1));
    assign idx_x    = XW'(req.data.read_index);
    assign idx_ok   = (idx_x < XW'(CELLS));

    assign req.ready = (state_reg == ST_IDLE);
    assign rsp.valid = ovld_reg;
    assign rsp.data  = odata_reg;

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        pend_next  = pend_reg;
        fill_next  = fill_reg;
        fresp_next = fresp_reg;
        rsel_next  = rsel_reg;
        ovld_next  = ovld_reg & ~rsp.ready;
        odata_next = odata_reg;
        ram_we     = 1'b0;
        ram_waddr  = pos;
        ram_wdata  = BLANK_CELL;
        ram_re     = 1'b0;
        ram_raddr  = src_reg;
        line_feed  = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    rsel_next  = 1'b0;
                    state_next = ST_RESP;
                    case (req.data.func)
                        FN_PUT:
                        begin
                            ram_we    = 1'b1;
                            ram_wdata = {req.data.attribute, req.data.char_code};
                            if (col_last)
                            begin
                                line_feed = 1'b1;
                            end
                            else
                            begin
                                col_next = col_reg + 1'b1;
                            end
                        end
                        FN_NEWLINE:
                        begin
                            line_feed = 1'b1;
                        end
                        FN_BACKSPACE:
                        begin
                            // nothing at column zero
                            if (col_reg != '0)
                            begin
                                col_next  = col_reg - 1'b1;
                                ram_we    = 1'b1;
                                ram_waddr = pos - 1'b1;
                            end
                        end
                        FN_CLEAR:
                        begin
                            row_next   = '0;
                            col_next   = '0;
                            fill_next  = '0;
                            fresp_next = 1'b1;
                            state_next = ST_FILL;
                        end
                        FN_READ:
                        begin
                            ram_re    = idx_ok;
                            ram_raddr = AW'(idx_x);
                            rsel_next = idx_ok;
                        end
                        default:
                        begin
                        end
                    endcase
                    if (line_feed)
                    begin
                        col_next = '0;
                        if (row_last)
                        begin
                            src_next   = AW'(COLS);
                            pend_next  = 1'b0;
                            state_next = ST_SCROLL;
                        end
                        else
                        begin
                            row_next = row_reg + 1'b1;
                        end
                    end
                end
            end
            ST_SCROLL:
            begin
                // read one cell per cycle, write it one row up in the next cycle
                ram_re    = 1'b1;
                ram_raddr = src_reg;
                pend_next = 1'b1;
                dst_next  = src_reg - AW'(COLS);
                ram_we    = pend_reg;
                ram_waddr = dst_reg;
                ram_wdata = ram_rdata;
                if (src_reg == AW'(CELLS - 1))
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    src_next = src_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                // last copy, then blank the bottom row
                ram_we     = 1'b1;
                ram_waddr  = dst_reg;
                ram_wdata  = ram_rdata;
                pend_next  = 1'b0;
                fill_next  = AW'(CELLS - COLS);
                fresp_next = 1'b1;
                state_next = ST_FILL;
            end
            ST_FILL:
            begin
                ram_we    = 1'b1;
                ram_waddr = fill_reg;
                if (fill_reg == AW'(CELLS - 1))
                begin
                    state_next = fresp_reg ? ST_RESP : ST_IDLE;
                end
                else
                begin
                    fill_next = fill_reg + 1'b1;
                end
            end
            ST_RESP:
            begin
                // load the output register once it is free
                if (!ovld_reg || rsp.ready)
                begin
                    ovld_next             = 1'b1;
                    odata_next.cursor_row = 5'(row_reg);
                    odata_next.cursor_col = 7'(col_reg);
                    odata_next.read_char  = rsel_reg ? ram_rdata[7:0] : 8'h00;
                    odata_next.read_attr  = rsel_reg ? ram_rdata[15:8] : 8'h00;
                    state_next            = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // reset starts the clearing pass over the whole screen
            state_reg <= ST_FILL;
            row_reg   <= '0;
            col_reg   <= '0;
            src_reg   <= '0;
            dst_reg   <= '0;
            pend_reg  <= 1'b0;
            fill_reg  <= '0;
            fresp_reg <= 1'b0;
            rsel_reg  <= 1'b0;
            ovld_reg  <= 1'b0;
            odata_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            src_reg   <= src_next;
            dst_reg   <= dst_next;
            pend_reg  <= pend_next;
            fill_reg  <= fill_next;
            fresp_reg <= fresp_next;
            rsel_reg  <= rsel_next;
            ovld_reg  <= ovld_next;
            odata_reg <= odata_next;
        end
    end

endmodule

/* rtl/tcw_ram.sv */
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // read data holds until the next read
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/tcw_check.sv */
module tcw_check
    import tcw_pkg::*;
#(
    parameter int ROWS = 25,
    parameter int COLS = 80
) (
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp_data
);

    // stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("response changed while stalled");

    // one request at a time: busy right after a request transfer
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

    // cursor always on screen
    a_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_data.cursor_col < COLS) && (rsp_data.cursor_row < ROWS))
        else $error("cursor off screen");

    // clearing pass keeps requests out right after reset
    a_clear_pass: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !req_ready && !rsp_valid)
        else $error("ready during clearing pass");

endmodule

bind text_console_writer tcw_check #(
    .ROWS (ROWS),
    .COLS (COLS)
) u_tcw_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);
